### hdl/lfpo_pkg.sv
// ----------------------------------------------------------------------------
// lfpo_pkg
// Shared types and constants for the stack and fifo tag store pair.
// ----------------------------------------------------------------------------
package lfpo_pkg;

   // default sizes
   localparam int STORE_DEPTH_DEF = 64;
   localparam int TAG_BITS_DEF    = 16;

   // request codes
   typedef enum logic [1:0] {
      REQ_ADD        = 2'd0,
      REQ_TAKE_STACK = 2'd1,
      REQ_TAKE_FIFO  = 2'd2,
      REQ_TAKE_ANY   = 2'd3
   } req_code_type;

   // item kinds for adds, other codes are rejected
   localparam logic [1:0] KIND_STACK = 2'd0;
   localparam logic [1:0] KIND_FIFO  = 2'd1;

   // result status codes
   typedef enum logic [1:0] {
      ST_ADDED  = 2'd0,
      ST_SERVED = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_REJECT = 2'd3
   } status_type;

   // source of a served tag
   localparam logic FROM_STACK = 1'b0;
   localparam logic FROM_FIFO  = 1'b1;

endpackage

### hdl/lfpo_req_if.sv
// ----------------------------------------------------------------------------
// lfpo_req_if
// Request channel: valid/ready handshake with request code, kind and tag.
// ----------------------------------------------------------------------------
interface lfpo_req_if #(
   parameter int TAG_BITS = lfpo_pkg::TAG_BITS_DEF
);
   import lfpo_pkg::*;

   logic                valid;
   logic                ready;
   req_code_type        req_type;
   logic [1:0]          item_kind;
   logic [TAG_BITS-1:0] item_tag;

   modport source (output valid, output req_type, output item_kind, output item_tag,
                   input ready);
   modport sink   (input valid, input req_type, input item_kind, input item_tag,
                   output ready);
endinterface

### hdl/lfpo_rsp_if.sv
// ----------------------------------------------------------------------------
// lfpo_rsp_if
// Result channel: valid/ready handshake with status, source and tag.
// ----------------------------------------------------------------------------
interface lfpo_rsp_if #(
   parameter int TAG_BITS = lfpo_pkg::TAG_BITS_DEF
);
   import lfpo_pkg::*;

   logic                valid;
   logic                ready;
   status_type          status;
   logic                served_from;
   logic [TAG_BITS-1:0] out_tag;

   modport source (output valid, output status, output served_from, output out_tag,
                   input ready);
   modport sink   (input valid, input status, input served_from, input out_tag,
                   output ready);
endinterface

### hdl/lifo_fifo_pair_with_occupancy_pick_unit.sv
// ----------------------------------------------------------------------------
// lifo_fifo_pair_with_occupancy_pick_unit
// Stack and fifo tag stores in synchronous memories; adds push by kind,
// takes pop their own store or the fuller one, one status per request.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake      payload
//  req_chan  in         valid/ready    req_type, item_kind, item_tag
//  rsp_chan  out        valid/ready    status, served_from, out_tag
//
// One request per cycle: counters and memory access happen at acceptance, the
// memory read data is formatted into the output register when the middle stage
// moves on, so each result passes the middle stage and then the output register.
// Reset (synchronous) empties both stores; memory contents are not cleared.
// A stalled result holds the middle stage, which then blocks new requests.
//
module lifo_fifo_pair_with_occupancy_pick_unit #(
   parameter int STORE_DEPTH = lfpo_pkg::STORE_DEPTH_DEF,
   parameter int TAG_BITS    = lfpo_pkg::TAG_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   lfpo_req_if.sink req_chan,
   lfpo_rsp_if.source rsp_chan
);
   import lfpo_pkg::*;

   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);

   // storage
   logic [TAG_BITS-1:0] stack_mem [STORE_DEPTH];
   logic [TAG_BITS-1:0] fifo_mem  [STORE_DEPTH];
   logic [TAG_BITS-1:0] stack_rd_ff;
   logic [TAG_BITS-1:0] fifo_rd_ff;

   // occupancy state
   logic [CNT_W-1:0] stack_count_ff, stack_count_in;
   logic [CNT_W-1:0] fifo_count_ff, fifo_count_in;
   logic [IDX_W-1:0] fifo_head_ff, fifo_head_in;
   logic [IDX_W-1:0] fifo_tail_ff, fifo_tail_in;

   // middle stage and output register
   logic       s1_valid_ff;
   status_type s1_status_ff, s1_status_in;
   logic       s1_from_ff, s1_from_in;
   logic                rsp_valid_ff;
   status_type          rsp_status_ff;
   logic                rsp_from_ff;
   logic [TAG_BITS-1:0] rsp_tag_ff, rsp_tag_in;

   logic accept;
   logic s1_move;
   logic req_ready;
   logic push_stack, push_fifo, pop_stack, pop_fifo;
   logic use_stack;
   logic stack_full, fifo_full;
   logic [CNT_W-1:0] stack_dec;

   // handshake
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   assign stack_full = (stack_count_ff == CNT_W'(STORE_DEPTH));
   assign fifo_full  = (fifo_count_ff  == CNT_W'(STORE_DEPTH));
   assign stack_dec  = stack_count_ff - 1'b1;

   // request decode
   always_comb begin
      push_stack   = 1'b0;
      push_fifo    = 1'b0;
      pop_stack    = 1'b0;
      pop_fifo     = 1'b0;
      use_stack    = 1'b0;
      s1_status_in = ST_EMPTY;
      s1_from_in   = FROM_STACK;
      case (req_chan.req_type)
         REQ_ADD: begin
            s1_status_in = ST_REJECT;
            if (req_chan.item_kind == KIND_STACK && !stack_full) begin
               push_stack   = 1'b1;
               s1_status_in = ST_ADDED;
            end else if (req_chan.item_kind == KIND_FIFO && !fifo_full) begin
               push_fifo    = 1'b1;
               s1_status_in = ST_ADDED;
            end
         end
         REQ_TAKE_STACK: use_stack = 1'b1;
         REQ_TAKE_FIFO:  use_stack = 1'b0;
         REQ_TAKE_ANY:   use_stack = (stack_count_ff > fifo_count_ff);
         default:        use_stack = 1'b0;
      endcase
      if (req_chan.req_type != REQ_ADD) begin
         if (use_stack && stack_count_ff != '0) begin
            pop_stack    = 1'b1;
            s1_status_in = ST_SERVED;
            s1_from_in   = FROM_STACK;
         end else if (!use_stack && fifo_count_ff != '0) begin
            pop_fifo     = 1'b1;
            s1_status_in = ST_SERVED;
            s1_from_in   = FROM_FIFO;
         end
      end
   end

   // counter and pointer updates
   always_comb begin
      stack_count_in = stack_count_ff;
      fifo_count_in  = fifo_count_ff;
      fifo_head_in   = fifo_head_ff;
      fifo_tail_in   = fifo_tail_ff;
      if (accept) begin
         if (push_stack) stack_count_in = stack_count_ff + 1'b1;
         if (pop_stack)  stack_count_in = stack_dec;
         if (push_fifo) begin
            fifo_count_in = fifo_count_ff + 1'b1;
            fifo_tail_in  = (fifo_tail_ff == IDX_W'(STORE_DEPTH - 1)) ? '0
                                                                      : fifo_tail_ff + 1'b1;
         end
         if (pop_fifo) begin
            fifo_count_in = fifo_count_ff - 1'b1;
            fifo_head_in  = (fifo_head_ff == IDX_W'(STORE_DEPTH - 1)) ? '0
                                                                      : fifo_head_ff + 1'b1;
         end
      end
   end

   // stack memory, one access per cycle
   always_ff @(posedge clock) begin
      if (accept && push_stack) begin
         stack_mem[stack_count_ff[IDX_W-1:0]] <= req_chan.item_tag;
      end
      if (accept && pop_stack) begin
         stack_rd_ff <= stack_mem[stack_dec[IDX_W-1:0]];
      end
   end

   // fifo memory, one access per cycle
   always_ff @(posedge clock) begin
      if (accept && push_fifo) begin
         fifo_mem[fifo_tail_ff] <= req_chan.item_tag;
      end
      if (accept && pop_fifo) begin
         fifo_rd_ff <= fifo_mem[fifo_head_ff];
      end
   end

   // result tag selection from the memory read data
   always_comb begin
      rsp_tag_in = '0;
      if (s1_status_ff == ST_SERVED) begin
         rsp_tag_in = (s1_from_ff == FROM_FIFO) ? fifo_rd_ff : stack_rd_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stack_count_ff <= '0;
         fifo_count_ff  <= '0;
         fifo_head_ff   <= '0;
         fifo_tail_ff   <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stack_count_ff <= stack_count_in;
         fifo_count_ff  <= fifo_count_in;
         fifo_head_ff   <= fifo_head_in;
         fifo_tail_ff   <= fifo_tail_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= s1_status_in;
         s1_from_ff   <= s1_from_in;
      end
      if (s1_move) begin
         rsp_status_ff <= s1_status_ff;
         rsp_from_ff   <= s1_from_ff;
         rsp_tag_ff    <= rsp_tag_in;
      end
   end

   // result channel
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.served_from = rsp_from_ff;
   assign rsp_chan.out_tag     = rsp_tag_ff;

endmodule
